FILE: rtl/core/linear_probe_hash_set_core_defines.svh
// Assertion macros shared by the hash set RTL.
`ifndef LINEAR_PROBE_HASH_SET_CORE_DEFINES_SVH
`define LINEAR_PROBE_HASH_SET_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LPHS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LPHS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/lphs_pkg.sv
// Types and codes shared by the hash set modules.
package lphs_pkg;

    localparam int KEY_W   = 32;
    localparam int HASH_W  = 8;
    localparam int COUNT_W = 8;
    localparam int STAT_W  = 32;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_FIND   = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_e;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_EXISTS    = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_CAPACITY  = 3'd4,
        ST_FULL      = 3'd5
    } status_e;

    typedef enum logic [1:0] {
        TAG_EMPTY = 2'd0,
        TAG_TOMB  = 2'd1,
        TAG_USED  = 2'd2
    } tag_e;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_PROBE,
        S_CLEAR,
        S_DONE
    } state_e;

    typedef struct packed {
        action_e             action;
        logic [KEY_W-1:0]    key;
        logic [HASH_W-1:0]   hash_index;
    } in_item_t;

    typedef struct packed {
        status_e             status;
        logic [KEY_W-1:0]    found_key;
        logic [COUNT_W-1:0]  used_count;
        logic [STAT_W-1:0]   search_count;
        logic [STAT_W-1:0]   collision_count;
    } out_item_t;

    // Bookkeeping events from the probe controller to the statistics block.
    typedef struct packed {
        logic search_inc;
        logic collision_inc;
        logic used_inc;
        logic used_dec;
        logic used_clr;
    } stat_evt_t;

endpackage

FILE: rtl/core/lphs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lphs_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/lphs_stats.sv
// Used-slot count and saturating search and collision counters.
module lphs_stats (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lphs_pkg::stat_evt_t         evt,
    output logic [lphs_pkg::COUNT_W-1:0] used_count,
    output logic [lphs_pkg::STAT_W-1:0]  search_count,
    output logic [lphs_pkg::STAT_W-1:0]  collision_count
);
    import lphs_pkg::*;

    logic [COUNT_W-1:0] used_reg,   used_next;
    logic [STAT_W-1:0]  search_reg, search_next;
    logic [STAT_W-1:0]  coll_reg,   coll_next;

    always_comb
    begin
        used_next   = used_reg;
        search_next = search_reg;
        coll_next   = coll_reg;
        if (evt.used_clr)
        begin
            used_next = '0;
        end
        else if (evt.used_inc)
        begin
            used_next = used_reg + COUNT_W'(1);
        end
        else if (evt.used_dec)
        begin
            used_next = used_reg - COUNT_W'(1);
        end
        // hold at all ones
        if (evt.search_inc && !(&search_reg))
        begin
            search_next = search_reg + STAT_W'(1);
        end
        if (evt.collision_inc && !(&coll_reg))
        begin
            coll_next = coll_reg + STAT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg   <= '0;
            search_reg <= '0;
            coll_reg   <= '0;
        end
        else
        begin
            used_reg   <= used_next;
            search_reg <= search_next;
            coll_reg   <= coll_next;
        end
    end

    assign used_count      = used_reg;
    assign search_count    = search_reg;
    assign collision_count = coll_reg;

endmodule

FILE: rtl/core/lphs_ctrl.sv
// Probe controller: walks the slot memory, writes back, sweeps after reset and on clear.
`include "linear_probe_hash_set_core_defines.svh"
module lphs_ctrl #(
    parameter int SLOT_BITS = 8,
    parameter int KW        = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  lphs_pkg::in_item_t           in_data,
    input  logic [lphs_pkg::COUNT_W-1:0] cap_limit,
    input  logic [lphs_pkg::COUNT_W-1:0] used_count,
    output lphs_pkg::stat_evt_t          evt,
    output logic                         res_valid,
    input  logic                         res_ready,
    output lphs_pkg::status_e            res_status,
    output logic [lphs_pkg::KEY_W-1:0]   res_key,
    output logic                         mem_we,
    output logic [SLOT_BITS-1:0]         mem_waddr,
    output logic [KW+1:0]                mem_wdata,
    output logic [SLOT_BITS-1:0]         mem_raddr,
    input  logic [KW+1:0]                mem_rdata
);
    import lphs_pkg::*;

    state_e               state_reg, state_next;
    action_e              action_reg, action_next;
    logic [KW-1:0]        key_reg, key_next;
    logic [SLOT_BITS-1:0] cur_reg, cur_next;
    logic [SLOT_BITS-1:0] addr_reg, addr_next;
    logic [SLOT_BITS-1:0] step_reg, step_next;
    logic [SLOT_BITS-1:0] pos_reg, pos_next;
    logic                 have_free_reg, have_free_next;
    status_e              status_reg, status_next;
    logic [KEY_W-1:0]     hit_reg, hit_next;

    logic                 accept;
    logic [KW-1:0]        in_key;
    logic [SLOT_BITS-1:0] in_home;
    tag_e                 rd_tag;
    logic [KW-1:0]        rd_key;
    logic                 slot_match;
    logic                 free_now;
    logic [SLOT_BITS-1:0] pos_sel;
    logic                 go_probe, go_done, go_clear, walk_end;

    assign accept  = in_valid && in_ready;
    assign in_key  = KW'(in_data.key);
    assign in_home = SLOT_BITS'(in_data.hash_index);
    assign rd_tag  = tag_e'(mem_rdata[KW +: 2]);
    assign rd_key  = mem_rdata[KW-1:0];
    assign slot_match = (rd_tag == TAG_USED) && (rd_key == key_reg);
    assign free_now   = have_free_reg || (rd_tag != TAG_USED);
    assign pos_sel    = have_free_reg ? pos_reg : cur_reg;

    // Datapath and outputs
    always_comb
    begin
        in_ready       = (state_reg == S_IDLE);
        res_valid      = (state_reg == S_DONE);
        res_status     = status_reg;
        res_key        = hit_reg;
        evt            = '0;
        mem_we         = 1'b0;
        mem_waddr      = addr_reg;
        mem_wdata      = '0;
        mem_raddr      = addr_reg;
        action_next    = action_reg;
        key_next       = key_reg;
        cur_next       = cur_reg;
        addr_next      = addr_reg;
        step_next      = step_reg;
        pos_next       = pos_reg;
        have_free_next = have_free_reg;
        status_next    = status_reg;
        hit_next       = hit_reg;
        go_probe       = 1'b0;
        go_done        = 1'b0;
        go_clear       = 1'b0;
        walk_end       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                mem_raddr = in_home;
                if (accept)
                begin
                    action_next    = in_data.action;
                    key_next       = in_key;
                    hit_next       = '0;
                    step_next      = '0;
                    have_free_next = 1'b0;
                    cur_next       = in_home;
                    addr_next      = in_home + SLOT_BITS'(1);
                    status_next    = ST_OK;
                    if (in_data.action == ACT_CLEAR)
                    begin
                        evt.used_clr = 1'b1;
                        addr_next    = '0;
                        go_clear     = 1'b1;
                    end
                    else if (in_key == '0)
                    begin
                        status_next = ST_INVALID;
                        go_done     = 1'b1;
                    end
                    else if (in_data.action == ACT_INSERT && used_count >= cap_limit)
                    begin
                        status_next = ST_CAPACITY;
                        go_done     = 1'b1;
                    end
                    else if (in_data.action != ACT_INSERT && used_count == '0)
                    begin
                        status_next = ST_NOT_FOUND;
                        go_done     = 1'b1;
                    end
                    else
                    begin
                        evt.search_inc = 1'b1;
                        go_probe       = 1'b1;
                    end
                end
            end
            S_PROBE:
            begin
                // rdata holds slot cur_reg; the read of addr_reg is in flight
                cur_next  = addr_reg;
                addr_next = addr_reg + SLOT_BITS'(1);
                step_next = step_reg + SLOT_BITS'(1);
                if (action_reg == ACT_INSERT)
                begin
                    if (slot_match)
                    begin
                        status_next = ST_EXISTS;
                        walk_end    = 1'b1;
                    end
                    else if (rd_tag == TAG_EMPTY)
                    begin
                        mem_we       = 1'b1;
                        mem_waddr    = pos_sel;
                        mem_wdata    = {TAG_USED, key_reg};
                        evt.used_inc = 1'b1;
                        status_next  = ST_OK;
                        walk_end     = 1'b1;
                    end
                    else
                    begin
                        evt.collision_inc = 1'b1;
                        have_free_next    = free_now;
                        pos_next          = pos_sel;
                        if (&step_reg)
                        begin
                            walk_end = 1'b1;
                            if (free_now)
                            begin
                                mem_we       = 1'b1;
                                mem_waddr    = pos_sel;
                                mem_wdata    = {TAG_USED, key_reg};
                                evt.used_inc = 1'b1;
                                status_next  = ST_OK;
                            end
                            else
                            begin
                                status_next = ST_FULL;
                            end
                        end
                    end
                end
                else
                begin
                    if (rd_tag == TAG_EMPTY)
                    begin
                        status_next = ST_NOT_FOUND;
                        walk_end    = 1'b1;
                    end
                    else if (slot_match)
                    begin
                        status_next = ST_OK;
                        walk_end    = 1'b1;
                        if (action_reg == ACT_REMOVE)
                        begin
                            mem_we       = 1'b1;
                            mem_waddr    = cur_reg;
                            mem_wdata    = {TAG_TOMB, key_reg};
                            evt.used_dec = 1'b1;
                        end
                        else
                        begin
                            hit_next = KEY_W'(rd_key);
                        end
                    end
                    else
                    begin
                        evt.collision_inc = 1'b1;
                        if (&step_reg)
                        begin
                            status_next = ST_FULL;
                            walk_end    = 1'b1;
                        end
                    end
                end
            end
            S_INIT, S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = addr_reg;
                mem_wdata = {TAG_EMPTY, {KW{1'b0}}};
                addr_next = addr_reg + SLOT_BITS'(1);
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (&addr_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (go_clear)
                begin
                    state_next = S_CLEAR;
                end
                else if (go_probe)
                begin
                    state_next = S_PROBE;
                end
                else if (go_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_PROBE:
            begin
                if (walk_end)
                begin
                    state_next = S_DONE;
                end
            end
            S_CLEAR:
            begin
                if (&addr_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            addr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg    <= action_next;
        key_reg       <= key_next;
        cur_reg       <= cur_next;
        step_reg      <= step_next;
        pos_reg       <= pos_next;
        have_free_reg <= have_free_next;
        status_reg    <= status_next;
        hit_reg       <= hit_next;
    end

    `LPHS_ASSERT_NEXT(a_write_ends_walk, (state_reg == S_PROBE) && mem_we,
        state_reg == S_DONE, "probe write did not end the walk")
    `LPHS_ASSERT_NEXT(a_insert_reports_ok, evt.used_inc,
        (state_reg == S_DONE) && (status_reg == ST_OK), "insert without ok status")
    `LPHS_ASSERT_NEXT(a_clear_sweeps_from_zero,
        (state_reg == S_IDLE) && in_valid && (in_data.action == ACT_CLEAR),
        (state_reg == S_CLEAR) && (addr_reg == '0), "clear did not start sweep at slot zero")
    `LPHS_ASSERT_NOW(a_search_on_accept, evt.search_inc,
        (state_reg == S_IDLE) && in_valid, "search counted outside an accepted transaction")

endmodule

FILE: rtl/core/linear_probe_hash_set_core.sv
// Top level of the linear-probing hash set: config register, slot memory, result register.
//
// Open-addressing hash set with linear probing over TABLE_SLOTS slots held
// in one synchronous memory (tag and key per slot). Each input transaction
// inserts, removes or finds a key starting at its home slot, or clears the
// set; each gives exactly one result transaction. Timing between accepts:
// A refused item (zero key, at capacity, lookup on an empty set) goes
// straight to its result without a walk; a walk visits n slots, one slot
// per cycle set by the single memory read port, so n runs from 1 to
// TABLE_SLOTS. Clear sweeps every slot, one per cycle. After reset the
// block runs the same sweep with in_ready low; configuration writes are
// taken throughout. A finished result sits in an output register, so the
// next transaction can start while it waits for out_ready. Write
// capacity_limit only while idle.
module linear_probe_hash_set_core #(
    parameter int TABLE_SLOTS = 256,
    parameter int KEY_BITS    = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  lphs_pkg::in_item_t           in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output lphs_pkg::out_item_t          out_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [lphs_pkg::COUNT_W-1:0] cfg_data
);
    import lphs_pkg::*;

    localparam int SLOT_BITS = $clog2(TABLE_SLOTS);
    // stored key width: keys arrive as KEY_W bits and are cut to KEY_BITS, at most KEY_W
    localparam int KW        = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;

    logic [COUNT_W-1:0]   cap_reg, cap_next;
    logic                 out_valid_reg, out_valid_next;
    out_item_t            out_data_reg, out_data_next;

    stat_evt_t            evt;
    logic [COUNT_W-1:0]   used_count;
    logic [STAT_W-1:0]    search_count;
    logic [STAT_W-1:0]    collision_count;
    logic                 res_valid, res_ready;
    status_e              res_status;
    logic [KEY_W-1:0]     res_key;
    logic                 mem_we;
    logic [SLOT_BITS-1:0] mem_waddr, mem_raddr;
    logic [KW+1:0]        mem_wdata, mem_rdata;

    // Slot memory: {tag, key} per slot
    lphs_ram #(
        .WIDTH (KW + 2),
        .DEPTH (TABLE_SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    lphs_ctrl #(
        .SLOT_BITS (SLOT_BITS),
        .KW        (KW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .cap_limit  (cap_reg),
        .used_count (used_count),
        .evt        (evt),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_status (res_status),
        .res_key    (res_key),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    lphs_stats u_stats (
        .clk             (clk),
        .rst_n           (rst_n),
        .evt             (evt),
        .used_count      (used_count),
        .search_count    (search_count),
        .collision_count (collision_count)
    );

    // Config register: always ready; the user must write it only while idle, the block does not enforce it
    assign cfg_ready = 1'b1;

    // Result register: take a new result when empty or being drained
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        cap_next       = cap_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (cfg_valid && cfg_ready)
        begin
            cap_next = cfg_data;
        end
        if (out_valid_reg && out_ready)
        begin
            // drop the delivered transaction
            out_valid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            // counters already include every event of this item
            out_valid_next                = 1'b1;
            out_data_next.status          = res_status;
            out_data_next.found_key       = res_key;
            out_data_next.used_count      = used_count;
            out_data_next.search_count    = search_count;
            out_data_next.collision_count = collision_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= {COUNT_W{1'b1}};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the linear-probing hash set core.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lphs_pkg::*;

    localparam int SLOTS       = 256;
    localparam int STALL_MAX   = 15;
    localparam int IDLE_LIMIT  = 5000;  // covers a full walk plus both stalls
    localparam int TAIL_CYCLES = 300;   // longest walk plus margin
    localparam int SHOW_MAX    = 10;

    localparam logic [KEY_W-1:0] FILL_BASE = 32'h5A00_0000;
    localparam logic [KEY_W-1:0] SPARE_KEY = 32'h0BAD_0000;

    // One row of the directed part: the transaction, and where the outcome is
    // obvious, the status, found key and used count typed in by hand.
    typedef struct {
        in_item_t           op;
        bit                 typed;
        status_e            status;
        logic [KEY_W-1:0]   found;
        logic [COUNT_W-1:0] used;
    } dir_row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    in_item_t           in_data;
    logic               out_valid;
    logic               out_ready;
    out_item_t          out_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [COUNT_W-1:0] cfg_data;

    // Shadow copy of the set, advanced once per accepted input transaction.
    logic [KEY_W-1:0]   shadow_keys [SLOTS];
    tag_e               shadow_tags [SLOTS];
    logic [COUNT_W-1:0] shadow_used;
    logic [COUNT_W-1:0] shadow_limit;
    logic [STAT_W-1:0]  shadow_searches;
    logic [STAT_W-1:0]  shadow_collisions;

    // Replies owed by the block, oldest first.
    out_item_t          replies_due [$];
    int unsigned        mismatch_count;

    // While set, the matching side runs without idle cycles.
    bit                 calm_in;
    bit                 calm_out;

    dir_row_t           directed_rows [22];

    linear_probe_hash_set_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Saturating bumps of the two statistics counters.
    function automatic void bump_searches();
        if (shadow_searches != '1)
            shadow_searches++;
    endfunction

    function automatic void bump_collisions();
        if (shadow_collisions != '1)
            shadow_collisions++;
    endfunction

    // Apply one set operation to the shadow copy and return the reply it earns.
    function automatic out_item_t apply_set_op(input in_item_t op);
        out_item_t          reply;
        logic [HASH_W-1:0]  slot;
        logic [HASH_W-1:0]  free_slot;
        bit                 have_free;
        bit                 stop;

        reply        = '0;
        reply.status = ST_OK;
        free_slot    = '0;
        have_free    = 1'b0;
        stop         = 1'b0;

        case (op.action)
            ACT_INSERT:
            begin
                if (op.key == '0)
                    reply.status = ST_INVALID;
                else if (shadow_used >= shadow_limit)
                    reply.status = ST_CAPACITY;
                else
                begin
                    bump_searches();
                    for (int k = 0; k < SLOTS && !stop; k++)
                    begin
                        slot = op.hash_index + HASH_W'(k);
                        if (shadow_tags[slot] == TAG_USED && shadow_keys[slot] == op.key)
                        begin
                            reply.status = ST_EXISTS;
                            stop = 1'b1;
                        end
                        else if (shadow_tags[slot] == TAG_EMPTY)
                        begin
                            // An empty slot ends the walk without counting a collision.
                            if (!have_free)
                            begin
                                free_slot = slot;
                                have_free = 1'b1;
                            end
                            stop = 1'b1;
                        end
                        else
                        begin
                            // Remember the first tombstone, keep walking.
                            if (shadow_tags[slot] == TAG_TOMB && !have_free)
                            begin
                                free_slot = slot;
                                have_free = 1'b1;
                            end
                            bump_collisions();
                        end
                    end
                    if (reply.status != ST_EXISTS)
                    begin
                        if (!have_free)
                            reply.status = ST_FULL;
                        else
                        begin
                            shadow_tags[free_slot] = TAG_USED;
                            shadow_keys[free_slot] = op.key;
                            shadow_used++;
                        end
                    end
                end
            end

            ACT_REMOVE, ACT_FIND:
            begin
                if (op.key == '0)
                    reply.status = ST_INVALID;
                else if (shadow_used == '0)
                    reply.status = ST_NOT_FOUND;  // no walk on an empty set
                else
                begin
                    bump_searches();
                    reply.status = ST_FULL;       // holds if every slot is passed
                    for (int k = 0; k < SLOTS && !stop; k++)
                    begin
                        slot = op.hash_index + HASH_W'(k);
                        if (shadow_tags[slot] == TAG_EMPTY)
                        begin
                            reply.status = ST_NOT_FOUND;
                            stop = 1'b1;
                        end
                        else if (shadow_tags[slot] == TAG_USED && shadow_keys[slot] == op.key)
                        begin
                            reply.status = ST_OK;
                            if (op.action == ACT_REMOVE)
                            begin
                                shadow_tags[slot] = TAG_TOMB;
                                shadow_used--;
                            end
                            else
                                reply.found_key = shadow_keys[slot];
                            stop = 1'b1;
                        end
                        else
                            bump_collisions();
                    end
                end
            end

            default:
            begin
                // Clear: empty every slot, keep the statistics.
                foreach (shadow_tags[i])
                    shadow_tags[i] = TAG_EMPTY;
                shadow_used = '0;
            end
        endcase

        reply.used_count      = shadow_used;
        reply.search_count    = shadow_searches;
        reply.collision_count = shadow_collisions;
        return reply;
    endfunction

    function automatic in_item_t op_of(input action_e act, input logic [KEY_W-1:0] key,
                                       input logic [HASH_W-1:0] home);
        in_item_t op;
        op.action     = act;
        op.key        = key;
        op.hash_index = home;
        return op;
    endfunction

    // Random transaction: mostly a small key pool whose homes pile up near the
    // top of the table and wrap, so walks cross clusters, tombstones and the
    // end of the array. A few are noise with any key and any home.
    function automatic in_item_t random_op();
        in_item_t    op;
        int unsigned pick;
        int unsigned pool_id;

        pick          = $urandom_range(0, 99);
        pool_id       = $urandom_range(1, 48);
        op.key        = pool_id * 32'h9E37_79B1;
        op.hash_index = 8'hF8 + HASH_W'(pool_id % 16);
        if (pick < 3)
            op.action = ACT_CLEAR;
        else if (pick < 45)
            op.action = ACT_INSERT;
        else if (pick < 70)
            op.action = ACT_REMOVE;
        else
            op.action = ACT_FIND;

        if (pick >= 92)
        begin
            op.key        = (pick >= 98) ? '0 : KEY_W'($urandom);
            op.hash_index = HASH_W'($urandom);
            op.action     = action_e'(2'($urandom_range(0, 2)));
        end
        return op;
    endfunction

    task automatic compare_field(input string name, input logic [STAT_W-1:0] want,
                                 input logic [STAT_W-1:0] got);
        if (want !== got)
        begin
            if (mismatch_count < SHOW_MAX)
                $display("%0t: %s expected %h, got %h", $realtime, name, want, got);
            mismatch_count++;
        end
    endtask

    // Check one accepted reply against the oldest one owed.
    task automatic take_reply(input out_item_t got);
        out_item_t want;

        if (replies_due.size() == 0)
        begin
            if (mismatch_count < SHOW_MAX)
                $display("%0t: reply with none outstanding: %h", $realtime, got);
            mismatch_count++;
        end
        else
        begin
            want = replies_due.pop_front();
            compare_field("status", STAT_W'(want.status), STAT_W'(got.status));
            compare_field("found_key", want.found_key, got.found_key);
            compare_field("used_count", STAT_W'(want.used_count), STAT_W'(got.used_count));
            compare_field("search_count", want.search_count, got.search_count);
            compare_field("collision_count", want.collision_count, got.collision_count);
        end
    endtask

    // Offer one input transaction after a random gap; on acceptance advance the
    // shadow set and queue the reply. Valid stays high after acceptance until
    // the next call (or drain) moves it at the following falling edge, so
    // back-to-back transactions never lower and raise valid in one step.
    task automatic send_op(input in_item_t op, input bit typed = 1'b0,
                           input status_e status = ST_OK,
                           input logic [KEY_W-1:0] found = '0,
                           input logic [COUNT_W-1:0] used = '0);
        int unsigned gap;
        out_item_t   reply;

        gap = calm_in ? 0 : $urandom_range(0, STALL_MAX);
        if ($urandom_range(0, 39) == 0)
            calm_in = !calm_in;

        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= op;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);

        reply = apply_set_op(op);
        // Hand-typed fields replace the predicted ones; counters stay predicted.
        if (typed)
        begin
            reply.status     = status;
            reply.found_key  = found;
            reply.used_count = used;
        end
        replies_due.push_back(reply);
    endtask

    // Drop valid and hold until every owed reply has come back.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
    endtask

    // Write capacity_limit with the block idle.
    task automatic write_limit(input logic [COUNT_W-1:0] value);
        drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        shadow_limit = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Result side: stall a random number of cycles per reply, with calm
    // stretches, then take the reply and check it.
    initial
    begin
        int unsigned hold;

        out_ready = 1'b0;
        calm_out  = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            hold = calm_out ? 0 : $urandom_range(0, STALL_MAX);
            if ($urandom_range(0, 39) == 0)
                calm_out = !calm_out;
            @(negedge clk);
            if (hold != 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            take_reply(out_data);
        end
    end

    // Watchdog: end the run once no transaction of any kind has moved for too long.
    initial
    begin
        int unsigned quiet_cycles;

        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    // Stimulus: directed rows, a fill to the limit that forces full-table
    // walks, then random phases under several capacity limits.
    initial
    begin
        int unsigned phase_limit [5];
        int unsigned phase_items [5];

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        calm_in        = 1'b0;
        mismatch_count = 0;

        foreach (shadow_tags[i])
            shadow_tags[i] = TAG_EMPTY;
        shadow_used       = '0;
        shadow_limit      = 8'd255;
        shadow_searches   = '0;
        shadow_collisions = '0;

        directed_rows = '{
            // Lookups and refusals on the empty set.
            '{'{ACT_FIND,   32'd5,         8'h00}, 1'b1, ST_NOT_FOUND, 32'd0, 8'd0},
            '{'{ACT_REMOVE, 32'd5,         8'h00}, 1'b1, ST_NOT_FOUND, 32'd0, 8'd0},
            '{'{ACT_INSERT, 32'd0,         8'h00}, 1'b1, ST_INVALID,   32'd0, 8'd0},
            '{'{ACT_FIND,   32'd0,         8'h00}, 1'b1, ST_INVALID,   32'd0, 8'd0},
            '{'{ACT_REMOVE, 32'd0,         8'h00}, 1'b1, ST_INVALID,   32'd0, 8'd0},
            // Largest key at the last slot, then duplicates and wrap-around.
            '{'{ACT_INSERT, 32'hFFFF_FFFF, 8'hFF}, 1'b1, ST_OK,        32'd0, 8'd1},
            '{'{ACT_INSERT, 32'hFFFF_FFFF, 8'hFF}, 1'b1, ST_EXISTS,    32'd0, 8'd1},
            '{'{ACT_FIND,   32'hFFFF_FFFF, 8'hFF}, 1'b1, ST_OK, 32'hFFFF_FFFF, 8'd1},
            '{'{ACT_INSERT, 32'd1,         8'hFF}, 1'b1, ST_OK,        32'd0, 8'd2},
            '{'{ACT_INSERT, 32'd2,         8'hFF}, 1'b1, ST_OK,        32'd0, 8'd3},
            '{'{ACT_FIND,   32'd2,         8'hFF}, 1'b0, ST_OK,        32'd0, 8'd0},
            // Tombstone in the middle of a cluster.
            '{'{ACT_REMOVE, 32'd1,         8'hFF}, 1'b1, ST_OK,        32'd0, 8'd2},
            '{'{ACT_FIND,   32'd2,         8'hFF}, 1'b0, ST_OK,        32'd0, 8'd0},
            '{'{ACT_FIND,   32'd1,         8'hFF}, 1'b0, ST_OK,        32'd0, 8'd0},
            '{'{ACT_INSERT, 32'd2,         8'hFF}, 1'b0, ST_OK,        32'd0, 8'd0},
            '{'{ACT_INSERT, 32'd3,         8'hFF}, 1'b0, ST_OK,        32'd0, 8'd0},
            '{'{ACT_FIND,   32'hAAAA_AAAA, 8'hAA}, 1'b0, ST_OK,        32'd0, 8'd0},
            '{'{ACT_INSERT, 32'h5555_5555, 8'h55}, 1'b0, ST_OK,        32'd0, 8'd0},
            // Clear, then lookups see an empty set again.
            '{'{ACT_CLEAR,  32'd0,         8'h00}, 1'b1, ST_OK,        32'd0, 8'd0},
            '{'{ACT_FIND,   32'hFFFF_FFFF, 8'hFF}, 1'b1, ST_NOT_FOUND, 32'd0, 8'd0},
            '{'{ACT_INSERT, 32'h8000_0000, 8'h80}, 1'b1, ST_OK,        32'd0, 8'd1},
            '{'{ACT_REMOVE, 32'h8000_0000, 8'h80}, 1'b1, ST_OK,        32'd0, 8'd0}
        };

        // Hold reset, then release it at a falling edge.
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_limit(8'd255);
        foreach (directed_rows[i])
            send_op(directed_rows[i].op, directed_rows[i].typed, directed_rows[i].status,
                    directed_rows[i].found, directed_rows[i].used);

        // Fill slots 0..254 at the highest limit, one key per home slot.
        send_op(op_of(ACT_CLEAR, '0, '0));
        for (int s = 0; s < SLOTS - 1; s++)
            send_op(op_of(ACT_INSERT, FILL_BASE ^ KEY_W'(s), HASH_W'(s)));
        send_op(op_of(ACT_INSERT, SPARE_KEY | 32'd1, 8'h10));         // at capacity
        send_op(op_of(ACT_REMOVE, FILL_BASE ^ 32'd7, 8'd7));          // tombstone at 7
        send_op(op_of(ACT_INSERT, SPARE_KEY | 32'd2, 8'hFF));         // takes the last empty
        // No empty slot left: misses walk the whole array and report full.
        send_op(op_of(ACT_FIND,   SPARE_KEY | 32'd3, 8'h03));
        send_op(op_of(ACT_REMOVE, SPARE_KEY | 32'd3, 8'h80));
        // A second tombstone frees room; insert walks all slots, lands on the first.
        send_op(op_of(ACT_REMOVE, FILL_BASE ^ 32'd20, 8'd20));
        send_op(op_of(ACT_INSERT, SPARE_KEY | 32'd3, 8'h00));
        send_op(op_of(ACT_FIND,   SPARE_KEY | 32'd3, 8'h00));
        send_op(op_of(ACT_CLEAR,  '0, '0));

        // Random phases; the limit is rewritten only with the block idle.
        phase_limit = '{1, 0, 12, $urandom_range(2, 254), 255};
        phase_items = '{120, 30, 230, 230, 230};
        foreach (phase_limit[p])
        begin
            write_limit(COUNT_W'(phase_limit[p]));
            repeat (phase_items[p])
            begin
                // Now and then hold off until the block has caught up.
                if ($urandom_range(0, 99) == 0)
                    drain();
                send_op(random_op());
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
